### rtl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the dirty tile tracker
// Request and response transaction layouts, request codes, pixel width.
// ----------------------------------------------------------------------------
package dtt_pkg;

	localparam int PIX_W = 9;

	localparam logic REQ_INVALIDATE = 1'b0;
	localparam logic REQ_TAKE_NEXT  = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [PIX_W-1:0] min_x;
		logic [PIX_W-1:0] min_y;
		logic [PIX_W-1:0] max_x;
		logic [PIX_W-1:0] max_y;
	} req_t;

	typedef struct packed {
		logic       tile_found;
		logic [9:0] tile_index;
		logic [4:0] tile_col;
		logic [4:0] tile_row;
	} rsp_t;

endpackage

### rtl/dirty_tile_tracker_core.sv
// ----------------------------------------------------------------------------
// dirty_tile_tracker_core: one-bit-per-tile dirty map with rectangle marking
//
// Usage: drive req and raise start while busy is low; the transaction is
// taken at that edge and busy stays high until the response is issued.
// Every request produces exactly one response: rsp is valid for the single
// cycle in which done is high, and the receiver cannot stall it.
// An invalidate request divides its four coordinates by TILE_SIZE on one shared
// reciprocal multiplier (one coordinate per cycle), clips the span, then
// read-modify-writes the row memory for each covered tile row, reading in
// ST_MRD and writing in ST_MWR. A take-next request picks the first
// non-empty row from a flag vector, reads that row, clears its lowest set
// bit and answers; when no tile is dirty it answers without a row read.
// The single row memory port keeps each read and write in separate states.
// A new request may be accepted in the cycle in which done is high.
// Reset clears the per-row flags, so the whole map reads as clean at once;
// the row memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module dirty_tile_tracker_core
	import dtt_pkg::*;
#(
	parameter int TILE_SIZE    = 16,
	parameter int TILES_ACROSS = 32,
	parameter int TILES_DOWN   = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int CW      = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
	localparam int RW      = (TILES_DOWN > 1) ? $clog2(TILES_DOWN) : 1;
	localparam int DIV_SH  = 18;
	localparam int RCP_W   = 18;
	localparam int RECIP   = (1 << DIV_SH) / TILE_SIZE + 1;
	localparam logic [RCP_W-1:0] RECIP_V = RCP_W'(RECIP);
	localparam logic [PIX_W-1:0] TA_V    = PIX_W'(TILES_ACROSS);
	localparam logic [PIX_W-1:0] TD_V    = PIX_W'(TILES_DOWN);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_CLIP = 3'd2;
	localparam logic [2:0] ST_MRD  = 3'd3;
	localparam logic [2:0] ST_MWR  = 3'd4;
	localparam logic [2:0] ST_FIND = 3'd5;
	localparam logic [2:0] ST_FRD  = 3'd6;
	localparam logic [2:0] ST_FWR  = 3'd7;

	logic [2:0]              state_q;
	req_t                    req_q;
	logic [1:0]              div_cnt_q;
	logic [PIX_W-1:0]        quot_q [4];
	logic [TILES_ACROSS-1:0] span_q;
	logic [RW-1:0]           row_q;
	logic [RW-1:0]           row_end_q;
	logic [TILES_DOWN-1:0]   flag_q;
	logic [TILES_ACROSS-1:0] rd_q;
	logic                    done_q;
	rsp_t                    rsp_q;

	logic [TILES_ACROSS-1:0] row_mem [TILES_DOWN];

	// shared divider: multiply by reciprocal of TILE_SIZE
	logic [PIX_W-1:0]       div_in;
	logic [PIX_W+RCP_W-1:0] prod;
	logic [PIX_W-1:0]       quot;

	always_comb begin
		case (div_cnt_q)
			2'd0:    div_in = req_q.min_x;
			2'd1:    div_in = req_q.max_x;
			2'd2:    div_in = req_q.min_y;
			default: div_in = req_q.max_y;
		endcase
	end

	assign prod = {{RCP_W{1'b0}}, div_in} * {{PIX_W{1'b0}}, RECIP_V};
	assign quot = prod[DIV_SH +: PIX_W];

	// clip and span
	logic                    skip;
	logic [PIX_W-1:0]        c1_clip;
	logic [PIX_W-1:0]        r1_clip;
	logic [TILES_ACROSS-1:0] span;

	always_comb begin
		skip = (req_q.min_x > req_q.max_x) || (req_q.min_y > req_q.max_y) ||
			(quot_q[0] >= TA_V) || (quot_q[2] >= TD_V);
		c1_clip = (quot_q[1] >= TA_V) ? TA_V - PIX_W'(1) : quot_q[1];
		r1_clip = (quot_q[3] >= TD_V) ? TD_V - PIX_W'(1) : quot_q[3];
		for (int i = 0; i < TILES_ACROSS; i++) begin
			span[i] = (PIX_W'(i) >= quot_q[0]) && (PIX_W'(i) <= c1_clip);
		end
	end

	// first non-empty row and lowest dirty column
	logic          any_row;
	logic [RW-1:0] first_row;
	logic [CW-1:0] first_col;
	logic [TILES_ACROSS-1:0] rd_clr;

	always_comb begin
		any_row   = |flag_q;
		first_row = '0;
		for (int i = TILES_DOWN - 1; i >= 0; i--) begin
			if (flag_q[i]) begin
				first_row = RW'(i);
			end
		end
		first_col = '0;
		for (int i = TILES_ACROSS - 1; i >= 0; i--) begin
			if (rd_q[i]) begin
				first_col = CW'(i);
			end
		end
		rd_clr = rd_q & ~(TILES_ACROSS'(1) << first_col);
	end

	// row memory: one port, registered read
	logic                    mem_we;
	logic [TILES_ACROSS-1:0] mem_wdata;

	always_comb begin
		mem_we    = (state_q == ST_MWR) || (state_q == ST_FWR);
		mem_wdata = (state_q == ST_FWR) ? rd_clr
			: ((flag_q[row_q] ? rd_q : '0) | span_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem[row_q] <= mem_wdata;
		end
		rd_q <= row_mem[row_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			flag_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						div_cnt_q <= '0;
						state_q   <= (req.req_type == REQ_TAKE_NEXT) ? ST_FIND : ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 2'd1;
					if (div_cnt_q == 2'd3) begin
						state_q <= ST_CLIP;
					end
				end
				ST_CLIP: begin
					if (skip) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MRD;
					end
				end
				ST_MRD: begin
					state_q <= ST_MWR;
				end
				ST_MWR: begin
					flag_q[row_q] <= 1'b1;
					if (row_q == row_end_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MRD;
					end
				end
				ST_FIND: begin
					if (any_row) begin
						state_q <= ST_FRD;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_FRD: begin
					state_q <= ST_FWR;
				end
				ST_FWR: begin
					flag_q[row_q] <= |rd_clr;
					done_q        <= 1'b1;
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == ST_DIV) begin
			quot_q[div_cnt_q] <= quot;
		end
		if (state_q == ST_CLIP) begin
			span_q    <= span;
			row_q     <= RW'(quot_q[2]);
			row_end_q <= RW'(r1_clip);
		end
		if (state_q == ST_MWR) begin
			row_q <= row_q + RW'(1);
		end
		if (state_q == ST_FIND) begin
			row_q <= first_row;
		end
		if (state_q == ST_FWR) begin
			rsp_q.tile_found <= 1'b1;
			rsp_q.tile_index <= 10'(int'(row_q) * TILES_ACROSS + int'(first_col));
			rsp_q.tile_col   <= 5'(first_col);
			rsp_q.tile_row   <= 5'(row_q);
		end else begin
			// acknowledgement and not-found both answer all zero
			rsp_q <= '0;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two responses in consecutive cycles");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.tile_found |-> rsp.tile_index == 10'd0 &&
		rsp.tile_col == 5'd0 && rsp.tile_row == 5'd0)
		else $error("not-found response carries a tile");

	a_flag_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FWR |-> rd_q != '0)
		else $error("flagged row read back empty");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for dirty_tile_tracker_core
// Directed invalidate/take-next cases, random rectangle bursts drained by
// take-next, then a full-screen case. A predictor keeps its own dirty map;
// every response is checked field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top
	import dtt_pkg::*;
();

	localparam int TILE_SIZE    = 16;
	localparam int TILES_ACROSS = 32;
	localparam int TILES_DOWN   = 32;
	localparam int PIX_MAX      = (1 << PIX_W) - 1;
	localparam int RANDOM_ITEMS = 1350;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 1000000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// predicted dirty map, one word per tile row
	bit [TILES_ACROSS-1:0] dirty_map [TILES_DOWN];
	rsp_t pending_tile_rsp [$];

	bit gaps_enabled = 1'b0;
	int cycle_count  = 0;
	int fail_count   = 0;
	int n_items      = 0;
	int n_inval      = 0;
	int n_degenerate = 0;
	int n_take       = 0;
	int n_found      = 0;
	int n_clean      = 0;
	int n_checked    = 0;

	dirty_tile_tracker_core #(
		.TILE_SIZE(TILE_SIZE),
		.TILES_ACROSS(TILES_ACROSS),
		.TILES_DOWN(TILES_DOWN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles, %0d responses outstanding",
				cycle_count, pending_tile_rsp.size());
			$display("** dirty_tile_tracker_core: FAILED **");
			$finish;
		end
	end

	// Mark a rectangle of tiles or take one tile in the predicted map; returns the expected response.
	function automatic rsp_t serve_tile_request(input req_t r);
		rsp_t answer;
		int c0, c1, r0, r1, y, c, hit;
		bit [TILES_ACROSS-1:0] span;
		answer = '0;
		if (r.req_type == REQ_INVALIDATE) begin
			if (r.min_x > r.max_x || r.min_y > r.max_y)
				return answer;
			c0 = r.min_x / TILE_SIZE;
			c1 = r.max_x / TILE_SIZE;
			r0 = r.min_y / TILE_SIZE;
			r1 = r.max_y / TILE_SIZE;
			if (c0 >= TILES_ACROSS || r0 >= TILES_DOWN)
				return answer;
			if (c1 >= TILES_ACROSS)
				c1 = TILES_ACROSS - 1;
			if (r1 >= TILES_DOWN)
				r1 = TILES_DOWN - 1;
			span = '0;
			for (c = c0; c <= c1; c++)
				span[c] = 1'b1;
			for (y = r0; y <= r1; y++)
				dirty_map[y] |= span;
			return answer;
		end
		for (y = 0; y < TILES_DOWN; y++) begin
			if (dirty_map[y] != '0) begin
				hit = 0;
				for (c = TILES_ACROSS - 1; c >= 0; c--)
					if (dirty_map[y][c])
						hit = c;
				dirty_map[y][hit] = 1'b0;
				answer.tile_found = 1'b1;
				answer.tile_index = 10'(y * TILES_ACROSS + hit);
				answer.tile_col   = 5'(hit);
				answer.tile_row   = 5'(y);
				return answer;
			end
		end
		return answer;
	endfunction

	function automatic int dirty_tiles();
		int total;
		total = 0;
		for (int y = 0; y < TILES_DOWN; y++)
			total += $countones(dirty_map[y]);
		return total;
	endfunction

	function automatic int pick_gap();
		int p;
		if (!gaps_enabled)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic req_t make_rect(input int x0, input int y0, input int x1, input int y1);
		req_t r;
		r.req_type = REQ_INVALIDATE;
		r.min_x    = PIX_W'(x0);
		r.min_y    = PIX_W'(y0);
		r.max_x    = PIX_W'(x1);
		r.max_y    = PIX_W'(y1);
		return r;
	endfunction

	// rectangle fields are ignored on take-next; fill them with noise anyway
	function automatic req_t make_take();
		req_t r;
		r = make_rect($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX),
			$urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
		r.req_type = REQ_TAKE_NEXT;
		return r;
	endfunction

	function automatic int clip_pix(input int v);
		return (v > PIX_MAX) ? PIX_MAX : v;
	endfunction

	function automatic req_t random_rect();
		int m, a, b, x0, x1, y0, y1;
		m = $urandom_range(0, 99);
		if (m < 8) begin
			a = $urandom_range(0, PIX_MAX - 1);
			b = $urandom_range(a + 1, PIX_MAX);
			if ($urandom_range(0, 1)) begin
				x0 = b; x1 = a;
				y0 = $urandom_range(0, PIX_MAX); y1 = $urandom_range(0, PIX_MAX);
			end else begin
				y0 = b; y1 = a;
				x0 = $urandom_range(0, PIX_MAX); x1 = $urandom_range(0, PIX_MAX);
			end
		end else if (m < 16) begin
			// wide strip, about one tile row high
			x0 = $urandom_range(0, 63);
			x1 = $urandom_range(PIX_MAX - 63, PIX_MAX);
			y0 = $urandom_range(0, PIX_MAX);
			y1 = clip_pix(y0 + $urandom_range(0, TILE_SIZE - 1));
		end else if (m < 22) begin
			// tall strip, about one tile column wide
			y0 = $urandom_range(0, 63);
			y1 = $urandom_range(PIX_MAX - 63, PIX_MAX);
			x0 = $urandom_range(0, PIX_MAX);
			x1 = clip_pix(x0 + $urandom_range(0, TILE_SIZE - 1));
		end else begin
			x0 = $urandom_range(0, PIX_MAX);
			x1 = clip_pix(x0 + $urandom_range(0, 47));
			y0 = $urandom_range(0, PIX_MAX);
			y1 = clip_pix(y0 + $urandom_range(0, 47));
		end
		return make_rect(x0, y0, x1, y1);
	endfunction

	task automatic issue_request(input req_t r);
		rsp_t answer;
		int gap;
		req   <= r;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		answer = serve_tile_request(r);
		pending_tile_rsp.push_back(answer);
		n_items++;
		if (r.req_type == REQ_TAKE_NEXT) begin
			n_take++;
			if (answer.tile_found)
				n_found++;
			else
				n_clean++;
		end else begin
			n_inval++;
			if (r.min_x > r.max_x || r.min_y > r.max_y)
				n_degenerate++;
		end
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic void check_field(input string name, input int exp, input int act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && done) begin
			if (pending_tile_rsp.size() == 0) begin
				$error("response with no request outstanding");
				fail_count++;
			end else begin
				exp_rsp = pending_tile_rsp.pop_front();
				n_checked++;
				check_field("tile_found", exp_rsp.tile_found, rsp.tile_found);
				check_field("tile_index", exp_rsp.tile_index, rsp.tile_index);
				check_field("tile_col", exp_rsp.tile_col, rsp.tile_col);
				check_field("tile_row", exp_rsp.tile_row, rsp.tile_row);
			end
		end
	end

	task automatic test_empty_map();
		req_t r;
		r = make_rect(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX);
		r.req_type = REQ_TAKE_NEXT;
		issue_request(r);
	endtask

	task automatic test_corners();
		issue_request(make_rect(0, 0, 0, 0));
		issue_request(make_take());
		issue_request(make_rect(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX));
		issue_request(make_take());
		issue_request(make_take());
	endtask

	task automatic test_inverted_rects();
		issue_request(make_rect(20, 0, 19, PIX_MAX));
		issue_request(make_rect(0, 300, PIX_MAX, 299));
		issue_request(make_rect(PIX_MAX, PIX_MAX, 0, 0));
		issue_request(make_take());
	endtask

	task automatic test_tile_edges();
		// one pixel either side of a tile corner touches four tiles
		issue_request(make_rect(TILE_SIZE - 1, TILE_SIZE - 1, TILE_SIZE, TILE_SIZE));
		repeat (5) issue_request(make_take());
		issue_request(make_rect(TILE_SIZE, 2 * TILE_SIZE, 2 * TILE_SIZE - 1, 3 * TILE_SIZE - 1));
		issue_request(make_take());
	endtask

	task automatic test_random_traffic(input int target);
		int n_rects;
		while (n_items < target) begin
			gaps_enabled = ($urandom_range(0, 3) != 0);
			n_rects = $urandom_range(1, 4);
			repeat (n_rects) begin
				issue_request(random_rect());
				if ($urandom_range(0, 4) == 0)
					issue_request(make_take());
			end
			while (dirty_tiles() != 0) begin
				if ($urandom_range(0, 19) == 0)
					issue_request(random_rect());
				else
					issue_request(make_take());
			end
			// probe the clean map most of the time
			if ($urandom_range(0, 2) != 0)
				issue_request(make_take());
		end
	endtask

	task automatic test_full_screen();
		gaps_enabled = 1'b1;
		issue_request(make_rect(0, 0, PIX_MAX, PIX_MAX));
		repeat (3) issue_request(make_take());
	endtask

	initial begin
		for (int y = 0; y < TILES_DOWN; y++)
			dirty_map[y] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_map();
		test_corners();
		test_inverted_rects();
		gaps_enabled = 1'b1;
		test_tile_edges();
		test_random_traffic(n_items + RANDOM_ITEMS);
		test_full_screen();

		start <= 1'b0;
		while (pending_tile_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d invalidates (%0d inverted) and %0d take-next requests",
			n_inval, n_degenerate, n_take);
		$display("Take-next found %0d tiles, hit a clean map %0d times; %0d responses checked",
			n_found, n_clean, n_checked);
		if (fail_count == 0)
			$display("** dirty_tile_tracker_core: PASSED **");
		else
			$display("** dirty_tile_tracker_core: FAILED **");
		$finish;
	end

endmodule
